// ===== hdl/m68kea_pkg.sv =====
`default_nettype none

package m68kea_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_REG = 2'd0;
    localparam logic [1:0] KIND_MEM = 2'd1;
    localparam logic [1:0] KIND_IMM = 2'd2;
    localparam logic [1:0] KIND_ILL = 2'd3;

    // Operand sizes.
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;
    // Size code that no instruction encodes; it always resolves as illegal.
    localparam logic [1:0] SIZE_BAD  = 2'd3;

    // Addressing modes.
    localparam logic [2:0] MODE_DREG   = 3'd0;
    localparam logic [2:0] MODE_AREG   = 3'd1;
    localparam logic [2:0] MODE_AIND   = 3'd2;
    localparam logic [2:0] MODE_POSTI  = 3'd3;
    localparam logic [2:0] MODE_PREDEC = 3'd4;
    localparam logic [2:0] MODE_DISP   = 3'd5;
    localparam logic [2:0] MODE_INDEX  = 3'd6;
    localparam logic [2:0] MODE_EXT    = 3'd7;

    // Sub-modes of mode 7.
    localparam logic [2:0] SUB_ABS_W  = 3'd0;
    localparam logic [2:0] SUB_ABS_L  = 3'd1;
    localparam logic [2:0] SUB_PC_DSP = 3'd2;
    localparam logic [2:0] SUB_PC_IDX = 3'd3;
    localparam logic [2:0] SUB_IMM    = 3'd4;

    localparam logic [2:0] REQ_STACK_REG = 3'd7;

    // Bit position in the index extension word that selects a long index.
    localparam int LONG_INDEX_POS = 11;

    typedef struct packed {
        logic        we;
        logic [3:0]  addr;
        logic [31:0] data;
    } t_rf_write;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [31:0] operand_value;
        logic [1:0]  ext_words_used;
    } t_ea_result;

endpackage

`default_nettype wire

// ===== hdl/m68k_effective_address_unit.sv =====
`default_nettype none

// 68000 effective address unit. Each transaction resolves one operand and
// returns its kind (register value, memory address, immediate or illegal
// mode), the address or value, and the number of extension words used;
// postincrement, predecrement and register-direct destination writes update
// the internal D0-D7/A0-A7 register file, which reset clears to zero. One
// transaction is accepted every cycle while the output is not stalled. At
// acceptance the request is registered and the register file is read
// synchronously; when stage one advances, the resolved operand is loaded
// into the output register and any register update is written. The
// result then sits in the output register until it is taken, and a
// stalled output holds back new input.
// Back-to-back transactions see each other's register updates.
module m68k_effective_address_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_req_type,
    input  wire logic [2:0]  i_mode,
    input  wire logic [2:0]  i_reg_num,
    input  wire logic [1:0]  i_size,
    input  wire logic [15:0] i_ext_word0,
    input  wire logic [15:0] i_ext_word1,
    input  wire logic [31:0] i_ext_address,
    input  wire logic [31:0] i_write_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [31:0]      o_address,
    output logic [31:0]      o_operand_value,
    output logic [1:0]       o_ext_words_used
);

    logic        r_s1_valid;
    logic        r_req_type;
    logic [2:0]  r_mode;
    logic [2:0]  r_reg_num;
    logic [1:0]  r_size;
    logic [15:0] r_ext_word0;
    logic [15:0] r_ext_word1;
    logic [31:0] r_ext_address;
    logic [31:0] r_write_data;

    logic                   r_out_valid;
    m68kea_pkg::t_ea_result r_result;

    logic                   accept;
    logic                   s1_advance;
    logic [31:0]            base_reg;
    logic [31:0]            index_reg;
    m68kea_pkg::t_ea_result result;
    m68kea_pkg::t_rf_write  wr_raw;
    m68kea_pkg::t_rf_write  wr;

    assign s1_advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign accept     = i_in_valid && o_in_ready;

    // The register update commits only when the transaction leaves stage one.
    always_comb begin
        wr    = wr_raw;
        wr.we = wr_raw.we && s1_advance;
    end

    m68kea_regfile u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr0 ({i_mode != m68kea_pkg::MODE_DREG, i_reg_num}),
        .i_rd_addr1 (i_ext_word0[15:12]),
        .i_wr       (wr),
        .o_rd_data0 (base_reg),
        .o_rd_data1 (index_reg)
    );

    m68kea_resolve u_resolve (
        .i_req_type    (r_req_type),
        .i_mode        (r_mode),
        .i_reg_num     (r_reg_num),
        .i_size        (r_size),
        .i_ext_word0   (r_ext_word0),
        .i_ext_word1   (r_ext_word1),
        .i_ext_address (r_ext_address),
        .i_write_data  (r_write_data),
        .i_base_reg    (base_reg),
        .i_index_reg   (index_reg),
        .o_result      (result),
        .o_wr          (wr_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type    <= i_req_type;
            r_mode        <= i_mode;
            r_reg_num     <= i_reg_num;
            r_size        <= i_size;
            r_ext_word0   <= i_ext_word0;
            r_ext_word1   <= i_ext_word1;
            r_ext_address <= i_ext_address;
            r_write_data  <= i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_result <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_result.kind;
    assign o_address        = r_result.address;
    assign o_operand_value  = r_result.operand_value;
    assign o_ext_words_used = r_result.ext_words_used;

endmodule

`default_nettype wire

// ===== hdl/m68kea_regfile.sv =====
`default_nettype none

module m68kea_regfile (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_rd_en,
    input  wire logic [3:0]            i_rd_addr0,
    input  wire logic [3:0]            i_rd_addr1,
    input  wire m68kea_pkg::t_rf_write i_wr,
    output logic      [31:0]           o_rd_data0,
    output logic      [31:0]           o_rd_data1
);

    logic [31:0] r_mem [16];
    logic [15:0] r_written;
    logic [31:0] r_rd_data0;
    logic [31:0] r_rd_data1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr.we) begin
            r_written[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Reads see a write made at the same edge, so a new transaction always
    // observes the update of the one just ahead of it.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.we && i_wr.addr == i_rd_addr0) begin
                r_rd_data0 <= i_wr.data;
            end else begin
                r_rd_data0 <= r_written[i_rd_addr0] ? r_mem[i_rd_addr0] : 32'd0;
            end
            if (i_wr.we && i_wr.addr == i_rd_addr1) begin
                r_rd_data1 <= i_wr.data;
            end else begin
                r_rd_data1 <= r_written[i_rd_addr1] ? r_mem[i_rd_addr1] : 32'd0;
            end
        end
    end

    assign o_rd_data0 = r_rd_data0;
    assign o_rd_data1 = r_rd_data1;

endmodule

`default_nettype wire

// ===== hdl/m68kea_resolve.sv =====
`default_nettype none

module m68kea_resolve (
    input  wire logic                   i_req_type,
    input  wire logic [2:0]             i_mode,
    input  wire logic [2:0]             i_reg_num,
    input  wire logic [1:0]             i_size,
    input  wire logic [15:0]            i_ext_word0,
    input  wire logic [15:0]            i_ext_word1,
    input  wire logic [31:0]            i_ext_address,
    input  wire logic [31:0]            i_write_data,
    input  wire logic [31:0]            i_base_reg,
    input  wire logic [31:0]            i_index_reg,
    output m68kea_pkg::t_ea_result      o_result,
    output m68kea_pkg::t_rf_write       o_wr
);

    logic [31:0] size_mask;
    logic [31:0] step;
    logic [31:0] disp16;
    logic [31:0] index_val;
    logic [31:0] index_term;
    logic [31:0] abs_long;
    logic [31:0] dec_addr;

    always_comb begin
        unique case (i_size)
            m68kea_pkg::SIZE_BYTE: size_mask = 32'h0000_00FF;
            m68kea_pkg::SIZE_WORD: size_mask = 32'h0000_FFFF;
            default:               size_mask = 32'hFFFF_FFFF;
        endcase
    end

    always_comb begin
        unique case (i_size)
            m68kea_pkg::SIZE_BYTE:
                step = (i_reg_num == m68kea_pkg::REQ_STACK_REG) ? 32'd2 : 32'd1;
            m68kea_pkg::SIZE_WORD: step = 32'd2;
            default:               step = 32'd4;
        endcase
    end

    assign disp16    = {{16{i_ext_word0[15]}}, i_ext_word0};
    assign index_val = i_ext_word0[m68kea_pkg::LONG_INDEX_POS] ? i_index_reg
                     : {{16{i_index_reg[15]}}, i_index_reg[15:0]};
    assign index_term = index_val + {{24{i_ext_word0[7]}}, i_ext_word0[7:0]};
    assign abs_long  = {i_ext_word0, i_ext_word1};
    assign dec_addr  = i_base_reg - step;

    always_comb begin
        o_result.kind           = m68kea_pkg::KIND_ILL;
        o_result.address        = 32'd0;
        o_result.operand_value  = 32'd0;
        o_result.ext_words_used = 2'd0;
        o_wr.we                 = 1'b0;
        o_wr.addr               = {1'b1, i_reg_num};
        o_wr.data               = 32'd0;

        if (i_size != m68kea_pkg::SIZE_BAD) begin
            unique case (i_mode)
                m68kea_pkg::MODE_DREG: begin
                    o_result.kind = m68kea_pkg::KIND_REG;
                    o_wr.addr     = {1'b0, i_reg_num};
                    if (i_req_type) begin
                        o_wr.we                = 1'b1;
                        o_wr.data              = (i_base_reg & ~size_mask)
                                               | (i_write_data & size_mask);
                        o_result.operand_value = i_write_data & size_mask;
                    end else begin
                        o_result.operand_value = i_base_reg & size_mask;
                    end
                end
                m68kea_pkg::MODE_AREG: begin
                    // Byte access to an address register is illegal.
                    if (i_size != m68kea_pkg::SIZE_BYTE) begin
                        o_result.kind = m68kea_pkg::KIND_REG;
                        if (i_req_type) begin
                            o_wr.we   = 1'b1;
                            o_wr.data = (i_size == m68kea_pkg::SIZE_WORD)
                                      ? {{16{i_write_data[15]}}, i_write_data[15:0]}
                                      : i_write_data;
                            o_result.operand_value = i_write_data & size_mask;
                        end else begin
                            o_result.operand_value = i_base_reg & size_mask;
                        end
                    end
                end
                m68kea_pkg::MODE_AIND: begin
                    o_result.kind    = m68kea_pkg::KIND_MEM;
                    o_result.address = i_base_reg;
                end
                m68kea_pkg::MODE_POSTI: begin
                    o_result.kind    = m68kea_pkg::KIND_MEM;
                    o_result.address = i_base_reg;
                    o_wr.we          = 1'b1;
                    o_wr.data        = i_base_reg + step;
                end
                m68kea_pkg::MODE_PREDEC: begin
                    o_result.kind    = m68kea_pkg::KIND_MEM;
                    o_result.address = dec_addr;
                    o_wr.we          = 1'b1;
                    o_wr.data        = dec_addr;
                end
                m68kea_pkg::MODE_DISP: begin
                    o_result.kind           = m68kea_pkg::KIND_MEM;
                    o_result.address        = i_base_reg + disp16;
                    o_result.ext_words_used = 2'd1;
                end
                m68kea_pkg::MODE_INDEX: begin
                    o_result.kind           = m68kea_pkg::KIND_MEM;
                    o_result.address        = i_base_reg + index_term;
                    o_result.ext_words_used = 2'd1;
                end
                default: begin
                    unique case (i_reg_num)
                        m68kea_pkg::SUB_ABS_W: begin
                            o_result.kind           = m68kea_pkg::KIND_MEM;
                            o_result.address        = disp16;
                            o_result.ext_words_used = 2'd1;
                        end
                        m68kea_pkg::SUB_ABS_L: begin
                            o_result.kind           = m68kea_pkg::KIND_MEM;
                            o_result.address        = abs_long;
                            o_result.ext_words_used = 2'd2;
                        end
                        m68kea_pkg::SUB_PC_DSP: begin
                            if (!i_req_type) begin
                                o_result.kind           = m68kea_pkg::KIND_MEM;
                                o_result.address        = i_ext_address + disp16;
                                o_result.ext_words_used = 2'd1;
                            end
                        end
                        m68kea_pkg::SUB_PC_IDX: begin
                            if (!i_req_type) begin
                                o_result.kind           = m68kea_pkg::KIND_MEM;
                                o_result.address        = i_ext_address + index_term;
                                o_result.ext_words_used = 2'd1;
                            end
                        end
                        m68kea_pkg::SUB_IMM: begin
                            if (!i_req_type) begin
                                o_result.kind = m68kea_pkg::KIND_IMM;
                                if (i_size == m68kea_pkg::SIZE_LONG) begin
                                    o_result.operand_value  = abs_long;
                                    o_result.ext_words_used = 2'd2;
                                end else begin
                                    o_result.operand_value  = {16'd0, i_ext_word0}
                                                            & size_mask;
                                    o_result.ext_words_used = 2'd1;
                                end
                            end
                        end
                        default: begin
                            o_result.kind = m68kea_pkg::KIND_ILL;
                        end
                    endcase
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_m68k_effective_address_unit.sv =====
`timescale 1ns / 1ps

typedef struct packed {
    logic        req_type;
    logic [2:0]  mode;
    logic [2:0]  reg_num;
    logic [1:0]  size;
    logic [15:0] ext_word0;
    logic [15:0] ext_word1;
    logic [31:0] ext_address;
    logic [31:0] write_data;
} t_ea_request;

class operand_scoreboard;
    logic [31:0]            shadow_regs [16];
    m68kea_pkg::t_ea_result expected_operands [$];
    int unsigned            error_count;
    int unsigned            checked_count;
    int unsigned            kind_seen [4];

    function new();
        foreach (shadow_regs[i]) shadow_regs[i] = '0;
        foreach (kind_seen[i]) kind_seen[i] = 0;
        error_count   = 0;
        checked_count = 0;
    endfunction

    function logic [31:0] sext_word(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function logic [31:0] index_term(logic [15:0] ext);
        logic [31:0] x;
        x = shadow_regs[ext[15:12]];
        if (!ext[m68kea_pkg::LONG_INDEX_POS]) x = sext_word(x[15:0]);
        return x + {{24{ext[7]}}, ext[7:0]};
    endfunction

    // Resolves one accepted request against the shadow register file.
    function void note_request(t_ea_request rq);
        m68kea_pkg::t_ea_result res;
        logic [31:0]            mask;
        logic [31:0]            step;
        logic [3:0]             an;
        logic [3:0]             dn;
        res.kind           = m68kea_pkg::KIND_ILL;
        res.address        = '0;
        res.operand_value  = '0;
        res.ext_words_used = '0;
        mask = (rq.size == m68kea_pkg::SIZE_BYTE) ? 32'h0000_00FF :
               (rq.size == m68kea_pkg::SIZE_WORD) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
        an = {1'b1, rq.reg_num};
        dn = {1'b0, rq.reg_num};
        if (rq.size == m68kea_pkg::SIZE_BYTE)
            step = (rq.reg_num == m68kea_pkg::REQ_STACK_REG) ? 32'd2 : 32'd1;
        else
            step = (rq.size == m68kea_pkg::SIZE_WORD) ? 32'd2 : 32'd4;

        if (rq.size != m68kea_pkg::SIZE_BAD) begin
            case (rq.mode)
                m68kea_pkg::MODE_DREG: begin
                    if (rq.req_type) begin
                        shadow_regs[dn] = (shadow_regs[dn] & ~mask)
                                        | (rq.write_data & mask);
                        res.operand_value = rq.write_data & mask;
                    end else begin
                        res.operand_value = shadow_regs[dn] & mask;
                    end
                    res.kind = m68kea_pkg::KIND_REG;
                end
                m68kea_pkg::MODE_AREG: begin
                    if (rq.size != m68kea_pkg::SIZE_BYTE) begin
                        if (rq.req_type) begin
                            shadow_regs[an] = (rq.size == m68kea_pkg::SIZE_WORD) ?
                                sext_word(rq.write_data[15:0]) : rq.write_data;
                            res.operand_value = rq.write_data & mask;
                        end else begin
                            res.operand_value = shadow_regs[an] & mask;
                        end
                        res.kind = m68kea_pkg::KIND_REG;
                    end
                end
                m68kea_pkg::MODE_AIND: begin
                    res.kind    = m68kea_pkg::KIND_MEM;
                    res.address = shadow_regs[an];
                end
                m68kea_pkg::MODE_POSTI: begin
                    res.kind        = m68kea_pkg::KIND_MEM;
                    res.address     = shadow_regs[an];
                    shadow_regs[an] = shadow_regs[an] + step;
                end
                m68kea_pkg::MODE_PREDEC: begin
                    shadow_regs[an] = shadow_regs[an] - step;
                    res.kind        = m68kea_pkg::KIND_MEM;
                    res.address     = shadow_regs[an];
                end
                m68kea_pkg::MODE_DISP: begin
                    res.kind           = m68kea_pkg::KIND_MEM;
                    res.address        = shadow_regs[an] + sext_word(rq.ext_word0);
                    res.ext_words_used = 2'd1;
                end
                m68kea_pkg::MODE_INDEX: begin
                    res.kind           = m68kea_pkg::KIND_MEM;
                    res.address        = shadow_regs[an] + index_term(rq.ext_word0);
                    res.ext_words_used = 2'd1;
                end
                default: begin
                    case (rq.reg_num)
                        m68kea_pkg::SUB_ABS_W: begin
                            res.kind           = m68kea_pkg::KIND_MEM;
                            res.address        = sext_word(rq.ext_word0);
                            res.ext_words_used = 2'd1;
                        end
                        m68kea_pkg::SUB_ABS_L: begin
                            res.kind           = m68kea_pkg::KIND_MEM;
                            res.address        = {rq.ext_word0, rq.ext_word1};
                            res.ext_words_used = 2'd2;
                        end
                        m68kea_pkg::SUB_PC_DSP: begin
                            if (!rq.req_type) begin
                                res.kind    = m68kea_pkg::KIND_MEM;
                                res.address = rq.ext_address + sext_word(rq.ext_word0);
                                res.ext_words_used = 2'd1;
                            end
                        end
                        m68kea_pkg::SUB_PC_IDX: begin
                            if (!rq.req_type) begin
                                res.kind    = m68kea_pkg::KIND_MEM;
                                res.address = rq.ext_address + index_term(rq.ext_word0);
                                res.ext_words_used = 2'd1;
                            end
                        end
                        m68kea_pkg::SUB_IMM: begin
                            if (!rq.req_type) begin
                                res.kind = m68kea_pkg::KIND_IMM;
                                if (rq.size == m68kea_pkg::SIZE_LONG) begin
                                    res.operand_value  = {rq.ext_word0, rq.ext_word1};
                                    res.ext_words_used = 2'd2;
                                end else begin
                                    res.operand_value  = {16'd0, rq.ext_word0} & mask;
                                    res.ext_words_used = 2'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            endcase
        end
        expected_operands.push_back(res);
    endfunction

    function void check_result(m68kea_pkg::t_ea_result act);
        m68kea_pkg::t_ea_result exp_res;
        if (expected_operands.size() == 0) begin
            $error("result with nothing outstanding: kind %0d address %h value %h",
                   act.kind, act.address, act.operand_value);
            error_count++;
            return;
        end
        exp_res = expected_operands.pop_front();
        checked_count++;
        kind_seen[exp_res.kind]++;
        if (act.kind !== exp_res.kind) begin
            $error("kind: expected %0d, got %0d", exp_res.kind, act.kind);
            error_count++;
        end
        if (act.address !== exp_res.address) begin
            $error("address: expected %h, got %h", exp_res.address, act.address);
            error_count++;
        end
        if (act.operand_value !== exp_res.operand_value) begin
            $error("operand_value: expected %h, got %h",
                   exp_res.operand_value, act.operand_value);
            error_count++;
        end
        if (act.ext_words_used !== exp_res.ext_words_used) begin
            $error("ext_words_used: expected %0d, got %0d",
                   exp_res.ext_words_used, act.ext_words_used);
            error_count++;
        end
    endfunction
endclass

module tb_m68k_effective_address_unit;

    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic        i_req_type      = 1'b0;
    logic [2:0]  i_mode          = '0;
    logic [2:0]  i_reg_num       = '0;
    logic [1:0]  i_size          = '0;
    logic [15:0] i_ext_word0     = '0;
    logic [15:0] i_ext_word1     = '0;
    logic [31:0] i_ext_address   = '0;
    logic [31:0] i_write_data    = '0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic [1:0]  o_kind;
    logic [31:0] o_address;
    logic [31:0] o_operand_value;
    logic [1:0]  o_ext_words_used;

    int unsigned       cycle_count = 0;
    int unsigned       stall_cycle = 0;
    operand_scoreboard sb = new();

    m68k_effective_address_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_mode           (i_mode),
        .i_reg_num        (i_reg_num),
        .i_size           (i_size),
        .i_ext_word0      (i_ext_word0),
        .i_ext_word1      (i_ext_word1),
        .i_ext_address    (i_ext_address),
        .i_write_data     (i_write_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_address        (o_address),
        .o_operand_value  (o_operand_value),
        .o_ext_words_used (o_ext_words_used)
    );

    always #4 i_clk = ~i_clk;

    // Input transactions are noted before output transactions of the same edge,
    // so the shadow register file always runs ahead of the results.
    always @(posedge i_clk) begin
        t_ea_request            rq;
        m68kea_pkg::t_ea_result res;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            rq = '{i_req_type, i_mode, i_reg_num, i_size, i_ext_word0, i_ext_word1,
                   i_ext_address, i_write_data};
            sb.note_request(rq);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            res = '{o_kind, o_address, o_operand_value, o_ext_words_used};
            sb.check_result(res);
        end
    end

    // The receiver cycles through always-ready, coin-flip, mostly-stalled and
    // periodic stretches.
    always @(posedge i_clk) begin
        stall_cycle <= stall_cycle + 1;
        case ((stall_cycle / 97) % 4)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            2:       i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= (stall_cycle % 5 != 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_m68k_effective_address_unit: errors");
            $finish;
        end
    end

    function automatic t_ea_request mk(logic wr, logic [2:0] md, logic [2:0] rn,
                                       logic [1:0] sz, logic [15:0] e0 = '0,
                                       logic [15:0] e1 = '0, logic [31:0] base = '0,
                                       logic [31:0] data = '0);
        t_ea_request rq;
        rq = '{wr, md, rn, sz, e0, e1, base, data};
        return rq;
    endfunction

    function automatic logic [31:0] pick_word32();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h0000_8000;
            4:       return 32'h0000_0080;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_ea_request random_request();
        t_ea_request rq;
        rq.mode      = 3'($urandom_range(0, 7));
        rq.reg_num   = 3'($urandom_range(0, 7));
        // Keep most mode 7 requests on the defined sub-modes.
        if (rq.mode == m68kea_pkg::MODE_EXT && $urandom_range(0, 9) != 0)
            rq.reg_num = 3'($urandom_range(m68kea_pkg::SUB_ABS_W, m68kea_pkg::SUB_IMM));
        rq.size        = ($urandom_range(0, 24) == 0) ? m68kea_pkg::SIZE_BAD
                                                      : 2'($urandom_range(0, 2));
        rq.req_type    = 1'($urandom_range(0, 1));
        rq.ext_word0   = 16'($urandom);
        rq.ext_word1   = 16'($urandom);
        rq.ext_address = pick_word32();
        rq.write_data  = pick_word32();
        return rq;
    endfunction

    task automatic send_item(t_ea_request rq);
        i_in_valid    <= 1'b1;
        i_req_type    <= rq.req_type;
        i_mode        <= rq.mode;
        i_reg_num     <= rq.reg_num;
        i_size        <= rq.size;
        i_ext_word0   <= rq.ext_word0;
        i_ext_word1   <= rq.ext_word1;
        i_ext_address <= rq.ext_address;
        i_write_data  <= rq.write_data;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Waits for a clock edge before checking the queue, so the transaction accepted at the current edge is noted.
    task automatic wait_for_drain();
        @(posedge i_clk);
        while (sb.expected_operands.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned burst_left;
        int unsigned gap;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register writes first, so the address modes on A0, A1 and A7 see nonzero bases.
        send_item(mk(1'b1, m68kea_pkg::MODE_DREG, 3'd0, m68kea_pkg::SIZE_LONG,
                     '0, '0, '0, 32'hFFFF_FFFF));
        send_item(mk(1'b1, m68kea_pkg::MODE_DREG, 3'd1, m68kea_pkg::SIZE_BYTE,
                     '0, '0, '0, 32'h1234_5680));
        send_item(mk(1'b1, m68kea_pkg::MODE_DREG, 3'd2, m68kea_pkg::SIZE_WORD,
                     '0, '0, '0, 32'hABCD_8001));
        send_item(mk(1'b1, m68kea_pkg::MODE_AREG, 3'd1, m68kea_pkg::SIZE_WORD,
                     '0, '0, '0, 32'h0000_8000));
        send_item(mk(1'b1, m68kea_pkg::MODE_AREG, 3'd0, m68kea_pkg::SIZE_LONG,
                     '0, '0, '0, 32'h8000_0000));
        send_item(mk(1'b1, m68kea_pkg::MODE_AREG, m68kea_pkg::REQ_STACK_REG,
                     m68kea_pkg::SIZE_LONG, '0, '0, '0, 32'h0000_1000));
        send_item(mk(1'b0, m68kea_pkg::MODE_DREG, 3'd0, m68kea_pkg::SIZE_BYTE));
        send_item(mk(1'b0, m68kea_pkg::MODE_AREG, 3'd1, m68kea_pkg::SIZE_BYTE));
        send_item(mk(1'b0, m68kea_pkg::MODE_AIND, 3'd0, m68kea_pkg::SIZE_LONG));
        send_item(mk(1'b0, m68kea_pkg::MODE_POSTI, m68kea_pkg::REQ_STACK_REG,
                     m68kea_pkg::SIZE_BYTE));
        send_item(mk(1'b1, m68kea_pkg::MODE_POSTI, 3'd3, m68kea_pkg::SIZE_BYTE));
        send_item(mk(1'b0, m68kea_pkg::MODE_PREDEC, m68kea_pkg::REQ_STACK_REG,
                     m68kea_pkg::SIZE_BYTE));
        send_item(mk(1'b1, m68kea_pkg::MODE_PREDEC, 3'd2, m68kea_pkg::SIZE_LONG));
        send_item(mk(1'b0, m68kea_pkg::MODE_DISP, 3'd1, m68kea_pkg::SIZE_WORD,
                     16'h8000));
        send_item(mk(1'b0, m68kea_pkg::MODE_INDEX, 3'd0, m68kea_pkg::SIZE_LONG,
                     16'h0880));
        send_item(mk(1'b1, m68kea_pkg::MODE_INDEX, 3'd7, m68kea_pkg::SIZE_WORD,
                     16'hA07F));
        send_item(mk(1'b0, m68kea_pkg::MODE_EXT, m68kea_pkg::SUB_ABS_W,
                     m68kea_pkg::SIZE_BYTE, 16'hFFFF));
        send_item(mk(1'b1, m68kea_pkg::MODE_EXT, m68kea_pkg::SUB_ABS_L,
                     m68kea_pkg::SIZE_LONG, 16'hDEAD, 16'hBEEF));
        send_item(mk(1'b0, m68kea_pkg::MODE_EXT, m68kea_pkg::SUB_PC_DSP,
                     m68kea_pkg::SIZE_WORD, 16'h8000, '0, 32'h0000_0010));
        send_item(mk(1'b0, m68kea_pkg::MODE_EXT, m68kea_pkg::SUB_PC_IDX,
                     m68kea_pkg::SIZE_LONG, 16'h2FFF, '0, 32'hFFFF_FFF0));
        send_item(mk(1'b0, m68kea_pkg::MODE_EXT, m68kea_pkg::SUB_IMM,
                     m68kea_pkg::SIZE_BYTE, 16'h12FF));
        send_item(mk(1'b0, m68kea_pkg::MODE_EXT, m68kea_pkg::SUB_IMM,
                     m68kea_pkg::SIZE_WORD, 16'hFFFF));
        send_item(mk(1'b0, m68kea_pkg::MODE_EXT, m68kea_pkg::SUB_IMM,
                     m68kea_pkg::SIZE_LONG, 16'h8000, 16'h0001));
        send_item(mk(1'b1, m68kea_pkg::MODE_EXT, m68kea_pkg::SUB_IMM,
                     m68kea_pkg::SIZE_WORD, 16'h1234));
        send_item(mk(1'b1, m68kea_pkg::MODE_EXT, m68kea_pkg::SUB_PC_DSP,
                     m68kea_pkg::SIZE_LONG, 16'h0004));
        for (int s = m68kea_pkg::SUB_IMM + 1; s <= 7; s++)
            send_item(mk(1'b0, m68kea_pkg::MODE_EXT, s[2:0], m68kea_pkg::SIZE_WORD));
        send_item(mk(1'b0, m68kea_pkg::MODE_DREG, 3'd0, m68kea_pkg::SIZE_BAD));

        burst_left = $urandom_range(1, 40);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                // Let the pipeline empty completely once mid-run.
                i_in_valid <= 1'b0;
                wait_for_drain();
            end
            send_item(random_request());
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        i_in_valid <= 1'b0;

        wait_for_drain();
        repeat (10) @(posedge i_clk);
        if (sb.expected_operands.size() != 0) begin
            $error("%0d results never arrived", sb.expected_operands.size());
            sb.error_count++;
        end

        $display("checked %0d operands: %0d register, %0d memory, %0d immediate, %0d illegal",
                 sb.checked_count, sb.kind_seen[m68kea_pkg::KIND_REG],
                 sb.kind_seen[m68kea_pkg::KIND_MEM], sb.kind_seen[m68kea_pkg::KIND_IMM],
                 sb.kind_seen[m68kea_pkg::KIND_ILL]);
        $display("finished in %0d cycles with %0d mismatches", cycle_count, sb.error_count);
        if (sb.error_count == 0)
            $display("tb_m68k_effective_address_unit: clean");
        else
            $display("tb_m68k_effective_address_unit: errors");
        $finish;
    end

endmodule

// ===== m68k_effective_address_unit.f =====
hdl/m68kea_pkg.sv
hdl/m68kea_regfile.sv
hdl/m68kea_resolve.sv
hdl/m68k_effective_address_unit.sv
verif/tb_m68k_effective_address_unit.sv
